FILE: rtl/core/path_search_forward_decider_core_assert.svh
// Assertion macros for the path search forward decider.
`ifndef PATH_SEARCH_FORWARD_DECIDER_CORE_ASSERT_SVH
`define PATH_SEARCH_FORWARD_DECIDER_CORE_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define PSFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/psfd_pkg.sv
//------------------------------------------------------------------------------
// psfd_pkg
// Types and constants shared by the path search forward decider.
//------------------------------------------------------------------------------
package psfd_pkg;

    localparam int MAX_HOPS       = 8;
    localparam int SOURCE_ENTRIES = 256;
    localparam int IDX_W          = $clog2(SOURCE_ENTRIES);

    localparam logic [2:0] ACT_LOW_SINR = 3'd0;
    localparam logic [2:0] ACT_DISCARD  = 3'd1;
    localparam logic [2:0] ACT_NOT_SINK = 3'd2;
    localparam logic [2:0] ACT_LOOP     = 3'd3;
    localparam logic [2:0] ACT_FULL     = 3'd4;
    localparam logic [2:0] ACT_FORWARD  = 3'd5;
    localparam logic [2:0] ACT_CONSUMED = 3'd6;

    localparam logic [2:0] CFG_OWN_ADDRESS  = 3'd0;
    localparam logic [2:0] CFG_SINK_ENABLED = 3'd1;
    localparam logic [2:0] CFG_METRIC_MODE  = 3'd2;
    localparam logic [2:0] CFG_MIN_SINR     = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd4;
    localparam logic [2:0] CFG_SNR_FLOOR    = 3'd5;

    localparam logic [15:0] Q_MAX = 16'h7FFF;

    typedef struct packed {
        logic signed [15:0] sinr;
        logic               packet_type;
        logic [7:0]         source_address;
        logic [7:0]         dest_address;
        logic [3:0]         hop_count;
        logic [63:0]        hop_list;
        logic signed [15:0] path_quality;
        logic [31:0]        now;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         action;
        logic               send_answer;
        logic signed [15:0] answer_quality;
        logic [3:0]         out_hop_count;
        logic [63:0]        out_hop_list;
        logic signed [15:0] out_quality;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         own_address;
        logic               sink_enabled;
        logic               metric_mode;
        logic signed [15:0] min_request_sinr;
        logic [31:0]        answer_timeout;
        logic signed [15:0] snr_floor;
    } cfg_t;

    // Classified job handed from the front to the back.
    typedef struct packed {
        logic [2:0]         action;
        logic               visit;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] newq;
        logic [31:0]        now;
        logic [3:0]         hop_count;
        logic [63:0]        hop_list;
        logic signed [15:0] quality;
    } job_t;

endpackage

FILE: rtl/core/path_search_forward_decider_core.sv
//------------------------------------------------------------------------------
// path_search_forward_decider_core
// Judges path search headers, forwards them and keeps the sink's path table.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         push / full        in_item_t
// result    out        pop / empty        out_item_t
// config    in         cfg_valid/ready    cfg_index, cfg_data
//
// The front classifies a header combinationally into a one-entry job register.
// The back steps through table read, decide and write, and result for each item,
// and takes a new job only when idle, after the last result is queued.
// The table valid bits clear at once on reset; no clearing pass is needed.
// A stalled result holds in the output register; the front can still take one header.
//------------------------------------------------------------------------------
`include "path_search_forward_decider_core_assert.svh"

module path_search_forward_decider_core import psfd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      in_ready;
    logic      job_valid, job_ready, res_valid;
    job_t      job;

    assign cfg_ready = 1'b1;
    assign full      = !in_ready;
    assign empty     = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address      <= 8'd1;
            cfg_reg.sink_enabled     <= 1'b0;
            cfg_reg.metric_mode      <= 1'b0;
            cfg_reg.min_request_sinr <= 16'sd0;
            cfg_reg.answer_timeout   <= 32'd1000;
            cfg_reg.snr_floor        <= 16'sh8000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS:  cfg_reg.own_address      <= cfg_data[7:0];
                CFG_SINK_ENABLED: cfg_reg.sink_enabled     <= cfg_data[0];
                CFG_METRIC_MODE:  cfg_reg.metric_mode      <= cfg_data[0];
                CFG_MIN_SINR:     cfg_reg.min_request_sinr <= cfg_data[15:0];
                CFG_TIMEOUT:      cfg_reg.answer_timeout   <= cfg_data;
                CFG_SNR_FLOOR:    cfg_reg.snr_floor        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    psfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (push),
        .in_item   (in_item),
        .in_ready  (in_ready),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    psfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .res_valid (res_valid),
        .res       (out_item),
        .res_ready (pop)
    );

    `PSFD_ASSERT(a_answer_quality_zero, out_item.send_answer || out_item.answer_quality == 16'sd0 || empty, "answer quality set without answer")
    `PSFD_ASSERT(a_answer_needs_sink, empty || !out_item.send_answer || out_item.action == ACT_CONSUMED || out_item.action == ACT_FORWARD || out_item.action == ACT_LOOP || out_item.action == ACT_FULL, "answer on a dropped header")
    `PSFD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_item), "result changed while stalled")

endmodule

FILE: rtl/core/psfd_front.sv
//------------------------------------------------------------------------------
// psfd_front
// Classifies one header and builds the forwarded header.
//------------------------------------------------------------------------------
module psfd_front import psfd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     in_ready,
    output logic     job_valid,
    output job_t     job,
    input  logic     job_ready
);

    logic               job_valid_reg;
    job_t               job_reg;
    job_t               job_next;
    logic signed [15:0] upd_q;
    logic               loop_hit;
    logic               is_bcast;
    logic               sink_here;

    always_comb
    begin
        loop_hit = 1'b0;
        for (int i = 0; i < MAX_HOPS; i++)
        begin
            if (i < int'(in_item.hop_count) && in_item.hop_list[8*i +: 8] == cfg.own_address)
                loop_hit = 1'b1;
        end
    end

    always_comb
    begin
        if (cfg.metric_mode)
            upd_q = (in_item.sinr < in_item.path_quality) ? in_item.sinr : in_item.path_quality;
        else if (in_item.path_quality < $signed(Q_MAX))
            upd_q = in_item.path_quality + 16'sd1;
        else
            upd_q = $signed(Q_MAX);
    end

    assign is_bcast  = (in_item.dest_address == 8'hFF);
    assign sink_here = in_item.dest_address == cfg.own_address && !is_bcast;

    always_comb
    begin
        job_next.visit     = 1'b0;
        job_next.idx       = in_item.source_address[IDX_W-1:0];
        job_next.newq      = cfg.metric_mode ? upd_q
                                             : $signed({12'd0, in_item.hop_count});
        job_next.now       = in_item.now;
        job_next.hop_count = in_item.hop_count;
        job_next.hop_list  = in_item.hop_list;
        job_next.quality   = in_item.path_quality;
        if (in_item.sinr < cfg.min_request_sinr)
            job_next.action = ACT_LOW_SINR;
        else if (in_item.packet_type || in_item.source_address == cfg.own_address
                 || in_item.dest_address == 8'd0)
            job_next.action = ACT_DISCARD;
        else if (sink_here)
        begin
            if (cfg.sink_enabled)
            begin
                job_next.action  = ACT_CONSUMED;
                job_next.visit   = 1'b1;
                job_next.quality = upd_q;
            end
            else
                job_next.action = ACT_NOT_SINK;
        end
        else
        begin
            if (is_bcast && cfg.sink_enabled)
            begin
                job_next.visit   = 1'b1;
                job_next.quality = upd_q;
            end
            if (loop_hit)
                job_next.action = ACT_LOOP;
            else if (in_item.hop_count >= 4'(MAX_HOPS))
                job_next.action = ACT_FULL;
            else
            begin
                job_next.action    = ACT_FORWARD;
                job_next.hop_list[{in_item.hop_count[2:0], 3'b000} +: 8] = cfg.own_address;
                job_next.hop_count = in_item.hop_count + 4'd1;
                job_next.quality   = upd_q;
            end
        end
    end

    assign in_ready  = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else if (in_ready)
            job_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            job_reg <= job_next;
    end

endmodule

FILE: rtl/core/psfd_back.sv
//------------------------------------------------------------------------------
// psfd_back
// Per-source best path table: read, decide, write back, then queue result.
//------------------------------------------------------------------------------
module psfd_back import psfd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_ready,
    output logic      res_valid,
    output out_item_t res,
    input  logic      res_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DEC   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    job_t                cur_reg;
    logic [SOURCE_ENTRIES-1:0] valid_reg;
    logic signed [15:0]  bq_mem [SOURCE_ENTRIES];
    logic [31:0]         bt_mem [SOURCE_ENTRIES];
    logic signed [15:0]  bq_rd_reg;
    logic [31:0]         bt_rd_reg;
    logic                ev_reg;
    logic                ans_reg;
    logic                res_valid_reg;
    out_item_t           res_reg;
    logic signed [15:0]  init_q;
    logic signed [15:0]  sq;
    logic [31:0]         st;
    logic                better, outdated, answer;

    assign init_q = cfg.metric_mode ? cfg.snr_floor : 16'sd0;
    assign sq     = ev_reg ? bq_rd_reg : init_q;
    assign st     = ev_reg ? bt_rd_reg : 32'd0;
    assign outdated = (cur_reg.now - st) > cfg.answer_timeout;
    assign better   = cfg.metric_mode ? (cur_reg.newq > sq) : (cur_reg.newq < sq);
    assign answer   = cur_reg.visit && (outdated || better || sq == init_q);

    assign job_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_READ;
            ST_READ: state_next = ST_DEC;
            ST_DEC:  state_next = ST_OUT;
            ST_OUT:  if (!res_valid_reg || res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DEC && cur_reg.visit)
                valid_reg[cur_reg.idx] <= 1'b1;
            if (state_reg == ST_OUT && (!res_valid_reg || res_ready))
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
            cur_reg <= job;
        if (state_reg == ST_READ)
        begin
            bq_rd_reg <= bq_mem[cur_reg.idx];
            bt_rd_reg <= bt_mem[cur_reg.idx];
            ev_reg    <= valid_reg[cur_reg.idx];
        end
        if (state_reg == ST_DEC)
        begin
            ans_reg <= answer;
            if (answer)
            begin
                bq_mem[cur_reg.idx] <= cur_reg.newq;
                bt_mem[cur_reg.idx] <= cur_reg.now;
            end
            else if (cur_reg.visit && !ev_reg)
            begin
                // A fresh entry that is not beaten still keeps its initial value.
                bq_mem[cur_reg.idx] <= init_q;
                bt_mem[cur_reg.idx] <= 32'd0;
            end
        end
        if (state_reg == ST_OUT && (!res_valid_reg || res_ready))
        begin
            res_reg.action         <= cur_reg.action;
            res_reg.send_answer    <= ans_reg;
            res_reg.answer_quality <= ans_reg ? cur_reg.newq : 16'sd0;
            res_reg.out_hop_count  <= cur_reg.hop_count;
            res_reg.out_hop_list   <= cur_reg.hop_list;
            res_reg.out_quality    <= cur_reg.quality;
        end
    end

endmodule

FILE: verif/path_search_forward_decider_core_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// path_search_forward_decider_core_tb
// Drives path search headers through the decider across several register
// settings. Each result is checked against an in-bench predictor that holds
// its own copy of the registers and of the per-source path table.
//------------------------------------------------------------------------------
module path_search_forward_decider_core_tb;
    import psfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    in_item;
    logic        empty;
    logic        pop;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    path_search_forward_decider_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the source table.
    logic [7:0]         own_addr_q;
    logic               sink_en_q;
    logic               snr_mode_q;
    logic signed [15:0] min_sinr_q;
    logic [31:0]        timeout_q;
    logic signed [15:0] floor_q;
    logic               tbl_valid [SOURCE_ENTRIES];
    logic signed [15:0] tbl_quality [SOURCE_ENTRIES];
    logic [31:0]        tbl_time [SOURCE_ENTRIES];

    out_item_t expected_results [$];
    int        mismatches;
    int        cycles;
    bit        rx_hold;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] next_quality(logic signed [15:0] sinr,
                                                        logic signed [15:0] q);
        if (snr_mode_q)
            return (sinr < q) ? sinr : q;
        return (q < 16'sh7FFF) ? q + 16'sd1 : 16'sh7FFF;
    endfunction

    // Updates the table entry of one source; sets answer and recorded quality.
    task automatic visit_sink(input logic [7:0] src, input logic [3:0] hops,
                              input logic signed [15:0] q, input logic [31:0] t,
                              inout out_item_t r);
        int                 idx;
        logic signed [15:0] init;
        logic signed [15:0] newq;
        logic [31:0]        age;
        bit                 better;
        idx  = src % SOURCE_ENTRIES;
        init = snr_mode_q ? floor_q : 16'sd0;
        newq = snr_mode_q ? q : $signed({12'd0, hops});
        if (!tbl_valid[idx])
        begin
            tbl_valid[idx]   = 1'b1;
            tbl_quality[idx] = init;
            tbl_time[idx]    = 32'd0;
        end
        age    = t - tbl_time[idx];
        better = snr_mode_q ? (newq > tbl_quality[idx]) : (newq < tbl_quality[idx]);
        if (age > timeout_q || better || tbl_quality[idx] == init)
        begin
            tbl_quality[idx] = newq;
            tbl_time[idx]    = t;
            r.send_answer    = 1'b1;
            r.answer_quality = newq;
        end
    endtask

    task automatic predict_header(input in_item_t h);
        out_item_t r;
        bit        qdone;
        bit        fwd;
        bit        looped;
        r.action         = ACT_LOW_SINR;
        r.send_answer    = 1'b0;
        r.answer_quality = '0;
        r.out_hop_count  = h.hop_count;
        r.out_hop_list   = h.hop_list;
        r.out_quality    = h.path_quality;
        qdone = 0;
        fwd   = 0;
        if (h.sinr < min_sinr_q)
            r.action = ACT_LOW_SINR;
        else if (h.packet_type || h.source_address == own_addr_q || h.dest_address == 8'd0)
            r.action = ACT_DISCARD;
        else if (h.dest_address == own_addr_q && h.dest_address != 8'd255)
        begin
            if (sink_en_q)
            begin
                r.out_quality = next_quality(h.sinr, h.path_quality);
                visit_sink(h.source_address, h.hop_count, r.out_quality, h.now, r);
                r.action = ACT_CONSUMED;
            end
            else
                r.action = ACT_NOT_SINK;
        end
        else
        begin
            if (h.dest_address == 8'd255 && sink_en_q)
            begin
                r.out_quality = next_quality(h.sinr, h.path_quality);
                qdone = 1;
                visit_sink(h.source_address, h.hop_count, r.out_quality, h.now, r);
            end
            fwd = 1;
        end
        if (fwd)
        begin
            looped = 0;
            for (int i = 0; i < MAX_HOPS; i++)
                if (i < h.hop_count && h.hop_list[8*i +: 8] == own_addr_q)
                    looped = 1;
            if (looped)
                r.action = ACT_LOOP;
            else if (h.hop_count >= MAX_HOPS)
                r.action = ACT_FULL;
            else
            begin
                r.out_hop_list[8*h.hop_count +: 8] = own_addr_q;
                r.out_hop_count = h.hop_count + 4'd1;
                if (!qdone)
                    r.out_quality = next_quality(h.sinr, h.path_quality);
                r.action = ACT_FORWARD;
            end
        end
        expected_results.push_back(r);
    endtask

    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, compare against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: %h", out_item);
            end
            else
            begin
                if (out_item !== expected_results[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h, actual %h",
                                 expected_results[0], out_item);
                end
                void'(expected_results.pop_front());
            end
        end
    end

    initial
    begin
        int g;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
                pop <= 1'b1;
            else
            begin
                g = gap_cycles();
                if (g == 0)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    repeat (g) @(negedge clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OWN_ADDRESS:  own_addr_q = val[7:0];
            CFG_SINK_ENABLED: sink_en_q  = val[0];
            CFG_METRIC_MODE:  snr_mode_q = val[0];
            CFG_MIN_SINR:     min_sinr_q = val[15:0];
            CFG_TIMEOUT:      timeout_q  = val;
            CFG_SNR_FLOOR:    floor_q    = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Push stays high after an accepted transaction until the next falling
    // edge, where it either carries the next header or drops.
    task automatic send_header(input in_item_t h, input bit nogap);
        int g;
        g = nogap ? 0 : gap_cycles();
        @(negedge clk);
        if (g != 0)
        begin
            push <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_item <= h;
        push    <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_header(h);
    endtask

    task automatic idle_input();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic drain();
        idle_input();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] own, input bit sink, input bit mode,
                                 input logic [15:0] minsinr, input logic [31:0] tmo,
                                 input logic [15:0] flr);
        drain();
        write_reg(CFG_OWN_ADDRESS, {24'd0, own});
        write_reg(CFG_SINK_ENABLED, {31'd0, sink});
        write_reg(CFG_METRIC_MODE, {31'd0, mode});
        write_reg(CFG_MIN_SINR, {16'd0, minsinr});
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_SNR_FLOOR, {16'd0, flr});
    endtask

    function automatic in_item_t random_header();
        in_item_t h;
        int       p;
        h.sinr           = 16'($urandom);
        h.packet_type    = ($urandom_range(0, 9) == 0);
        h.source_address = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        p = $urandom_range(0, 9);
        h.dest_address   = (p < 3) ? own_addr_q : (p < 6) ? 8'd255 :
                           (p == 6) ? 8'd0 : 8'($urandom);
        h.hop_count      = ($urandom_range(0, 15) == 0) ? 4'($urandom)
                                                        : 4'($urandom_range(0, 8));
        h.hop_list       = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            h.hop_list[8*$urandom_range(0, 7) +: 8] = own_addr_q;
        h.path_quality   = ($urandom_range(0, 7) == 0) ? 16'sh7FFF : 16'($urandom);
        if (!snr_mode_q && $urandom_range(0, 1))
            h.path_quality = 16'($urandom_range(0, 10));
        h.now            = ($urandom_range(0, 1)) ? $urandom_range(0, 3000) : $urandom;
        return h;
    endfunction

    // Directed rows: a header plus an optional typed-in expectation.
    typedef struct packed {
        in_item_t  hdr;
        bit        fixed;
        out_item_t res;
    } directed_row_t;

    directed_row_t rows [$];

    function automatic in_item_t hdr(logic [15:0] sinr, logic ptype, logic [7:0] src,
                                     logic [7:0] dst, logic [3:0] hops, logic [63:0] lst,
                                     logic [15:0] q, logic [31:0] t);
        in_item_t h;
        h = '{sinr, ptype, src, dst, hops, lst, q, t};
        return h;
    endfunction

    function automatic out_item_t echo(in_item_t h, logic [2:0] act);
        out_item_t r;
        r = '{act, 1'b0, 16'd0, h.hop_count, h.hop_list, h.path_quality};
        return r;
    endfunction

    initial
    begin
        in_item_t      h;
        clk = 0; rst_n = 0; push = 0; in_item = '0;
        cfg_valid = 0; cfg_index = CFG_OWN_ADDRESS; cfg_data = '0;
        cycles = 0; mismatches = 0; rx_hold = 0;
        own_addr_q = 8'd1; sink_en_q = 0; snr_mode_q = 0; min_sinr_q = 0;
        timeout_q = 32'd1000; floor_q = 16'sh8000;
        for (int i = 0; i < SOURCE_ENTRIES; i++)
        begin
            tbl_valid[i] = 0; tbl_quality[i] = 0; tbl_time[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Reset settings: low SINR, discard cases, not a sink, loop, full, two forwarded.
        h = hdr(16'h8000, 0, 5, 9, 0, 0, 0, 0);
        rows.push_back('{h, 1, echo(h, ACT_LOW_SINR)});
        h = hdr(16'h7FFF, 1, 5, 9, 0, 0, 0, 0);
        rows.push_back('{h, 1, echo(h, ACT_DISCARD)});
        h = hdr(0, 0, 1, 9, 0, 0, 0, 0);
        rows.push_back('{h, 1, echo(h, ACT_DISCARD)});
        h = hdr(0, 0, 5, 0, 0, 0, 0, 0);
        rows.push_back('{h, 1, echo(h, ACT_DISCARD)});
        h = hdr(0, 0, 5, 1, 2, 64'h0302, 3, 0);
        rows.push_back('{h, 1, echo(h, ACT_NOT_SINK)});
        h = hdr(0, 0, 5, 9, 3, 64'h010302, 3, 0);
        rows.push_back('{h, 1, echo(h, ACT_LOOP)});
        h = hdr(0, 0, 5, 9, 8, 64'hFFFF_FFFF_FFFF_FFFF, 3, 0);
        rows.push_back('{h, 1, echo(h, ACT_FULL)});
        h = hdr(0, 0, 5, 9, 15, 64'h0, 3, 0);
        rows.push_back('{h, 1, echo(h, ACT_FULL)});
        h = hdr(0, 0, 5, 9, 9, 64'h0100_0000_0000_0000, 3, 0);
        rows.push_back('{h, 1, echo(h, ACT_LOOP)});
        h = hdr(0, 0, 0, 255, 0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF);
        rows.push_back('{h, 0, '0});
        h = hdr(0, 0, 255, 9, 7, 64'h00FF_FFFF_FFFF_FFFF, 16'h8000, 0);
        rows.push_back('{h, 0, '0});
        foreach (rows[i])
        begin
            send_header(rows[i].hdr, 0);
            if (rows[i].fixed && expected_results[$] !== rows[i].res)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Predictor disagrees with table row %0d", i);
            end
        end

        // Sink in hop mode: new entry, repeat, outdated, broadcast visit.
        apply_setting(8'd255, 1, 0, 16'h8000, 32'd0, 16'h8000);
        send_header(hdr(0, 0, 5, 255, 2, 64'h0302, 16'h7FFF, 0), 0);
        apply_setting(8'd7, 1, 0, 16'h8000, 32'd10, 16'h8000);
        send_header(hdr(0, 0, 5, 7, 3, 64'h0302, 4, 100), 0);
        send_header(hdr(0, 0, 5, 7, 4, 64'h0302, 4, 105), 0);
        send_header(hdr(0, 0, 5, 7, 2, 64'h0302, 4, 106), 0);
        send_header(hdr(0, 0, 5, 7, 5, 64'h0302, 4, 200), 0);
        send_header(hdr(0, 0, 6, 255, 1, 64'h02, 16'h7FFF, 5), 0);
        send_header(hdr(0, 0, 6, 255, 0, 64'h0, 1, 6), 0);
        // SNR mode with the floor at its maximum and timeout at its maximum.
        apply_setting(8'd7, 1, 1, 16'hFF00, 32'hFFFF_FFFF, 16'h7FFF);
        send_header(hdr(16'h0100, 0, 9, 7, 1, 64'h02, 16'h0200, 10), 0);
        send_header(hdr(16'h0300, 0, 9, 7, 1, 64'h02, 16'h0200, 20), 0);
        send_header(hdr(16'h7FFF, 0, 9, 255, 1, 64'h02, 16'h7FFF, 30), 0);
        send_header(hdr(16'h0500, 0, 10, 255, 8, 64'h0, 16'h0100, 30), 0);

        // Random phases, each after a change of setting.
        for (int phase = 0; phase < 8; phase++)
        begin
            apply_setting(phase == 0 ? 8'd1 : 8'($urandom_range(1, 255)),
                          phase % 4 != 3, phase % 2,
                          phase == 2 ? 16'h7FFF : phase == 1 ? 16'h8000 :
                              16'($urandom_range(0, 1) ? 16'hE000 + $urandom_range(0, 8192) :
                                  $urandom),
                          phase == 4 ? 32'hFFFF_FFFF : phase == 5 ? 32'd0 :
                              $urandom_range(0, 2000),
                          phase == 3 ? 16'h8000 : 16'($urandom));
            rx_hold = (phase == 6);
            for (int k = 0; k < 62; k++)
            begin
                send_header(random_header(), phase == 6 || (k % 20) < 3);
                // Sender holds off once until every result has arrived.
                if (phase == 3 && k == 30)
                begin
                    idle_input();
                    while (expected_results.size() != 0)
                        @(posedge clk);
                end
            end
            rx_hold = 0;
        end

        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: path_search_forward_decider_core.f
+incdir+rtl/core
rtl/core/psfd_pkg.sv
rtl/core/psfd_front.sv
rtl/core/psfd_back.sv
rtl/core/path_search_forward_decider_core.sv
verif/path_search_forward_decider_core_tb.sv
